// ===== rtl/c_subset_token_scanner_assert.svh =====
// Assertion macros for the token scanner, clocked on aclk and disabled in reset.
`ifndef C_SUBSET_TOKEN_SCANNER_ASSERT_SVH
`define C_SUBSET_TOKEN_SCANNER_ASSERT_SVH

// Same-cycle implication.
`define CST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cst_pkg.sv =====
// Types, codes, keyword table and character classes for the token scanner.
`default_nettype none

package cst_pkg;

    // Scanner modes
    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_SLASH = 3'd1,
        M_LINE  = 3'd2,
        M_BLOCK = 3'd3,
        M_BSTAR = 3'd4,
        M_IDENT = 3'd5,
        M_CONST = 3'd6,
        M_ERROR = 3'd7
    } scan_mode_t;

    // Token types
    localparam logic [3:0] TOK_END    = 4'd0;
    localparam logic [3:0] TOK_INT    = 4'd1;
    localparam logic [3:0] TOK_VOID   = 4'd2;
    localparam logic [3:0] TOK_RETURN = 4'd3;
    localparam logic [3:0] TOK_IDENT  = 4'd4;
    localparam logic [3:0] TOK_CONST  = 4'd5;
    localparam logic [3:0] TOK_CMT    = 4'd6;
    localparam logic [3:0] TOK_LPAREN = 4'd7;
    localparam logic [3:0] TOK_RPAREN = 4'd8;
    localparam logic [3:0] TOK_LBRACE = 4'd9;
    localparam logic [3:0] TOK_RBRACE = 4'd10;
    localparam logic [3:0] TOK_SEMI   = 4'd11;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNTERM  = 2'd1;
    localparam logic [1:0] ERR_BADCONST = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN = 2'd3;

    // Input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Keyword spelling: int, void, return
    localparam logic [7:0] KW_TEXT [3][6] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}
    };
    localparam logic [2:0] KW_LEN [3] = '{3'd3, 3'd4, 3'd6};

    // One result item
    typedef struct packed {
        logic [3:0]  token_type;
        logic [1:0]  error_code;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last_of_run;
    } result_t;

    function automatic logic letter_byte(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic white_byte(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
    endfunction

    // Drop keyword candidates that do not match c at position idx (7 = past 6)
    function automatic logic [2:0] kw_filter(logic [2:0] alive, logic [2:0] idx,
                                             logic [7:0] c);
        logic [2:0] r;
        r = alive;
        for (int k = 0; k < 3; k++) begin
            if (idx < KW_LEN[k]) begin
                if (KW_TEXT[k][idx] != c) r[k] = 1'b0;
            end else begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // Keyword or identifier, from surviving candidates and the length code
    function automatic logic [3:0] ident_type(logic [2:0] alive, logic [2:0] idx);
        logic [3:0] t;
        t = TOK_IDENT;
        if (alive[2] && idx == KW_LEN[2]) t = TOK_RETURN;
        if (alive[1] && idx == KW_LEN[1]) t = TOK_VOID;
        if (alive[0] && idx == KW_LEN[0]) t = TOK_INT;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/c_subset_token_scanner.sv =====
// Streaming tokenizer for a small C subset: one byte per transfer, tokens out.
//
// Source bytes (s_tuser = 0) or an end-of-buffer mark (s_tuser = 1) enter one
// per cycle while s_tready is high. Each accepted item lands in an input
// register; once the result queue has room for two results, one pass of scanner
// logic updates the mode, position and length registers and writes zero, one
// or two results into a four-entry result queue, which feeds the master side.
// The block sustains one item per cycle as long as items give at most one
// result each and m_tready stays high; an item that gives two results needs two
// output transfers, since the single output port drains the queue one result a cycle.
// s_tready drops while the input register holds an item and the queue has
// fewer than two free entries. Counters are COUNTER_WIDTH bits and saturate;
// reported positions and lengths are clipped to 16 bits. An end-of-buffer
// item always returns the scanner to its reset state.
`default_nettype none

module c_subset_token_scanner #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [7:0] source_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // s_tuser: [0] kind
    input  wire logic        s_tuser,
    // m_tdata: [1:0] error_code, [17:2] start_line, [33:18] start_column,
    //          [49:34] token_length, [55:50] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,
    // m_tuser: [3:0] token_type
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);

    localparam int W = COUNTER_WIDTH;
    localparam logic [W-1:0] CNT_MAX = {W{1'b1}};
    localparam logic [W-1:0] CNT_ONE = W'(1);
    localparam int DEPTH = 4;

    function automatic logic [W-1:0] sat_inc(logic [W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [15:0] clip16(logic [W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        return (|v32[31:16]) ? 16'hFFFF : v32[15:0];
    endfunction

    function automatic cst_pkg::result_t mk_res(logic [3:0] t, logic [1:0] e,
                                                logic [W-1:0] ln, logic [W-1:0] cl,
                                                logic [W-1:0] len);
        cst_pkg::result_t r;
        r.token_type   = t;
        r.error_code   = e;
        r.start_line   = clip16(ln);
        r.start_column = clip16(cl);
        r.token_length = clip16(len);
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // Input register
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       stage_fire;

    // Scanner state
    cst_pkg::scan_mode_t mode_reg, mode_next;
    logic [W-1:0] cur_line_reg, cur_line_next;
    logic [W-1:0] cur_col_reg, cur_col_next;
    logic [W-1:0] tok_line_reg, tok_line_next;
    logic [W-1:0] tok_col_reg, tok_col_next;
    logic [W-1:0] len_reg, len_next;
    logic [2:0]   alive_reg, alive_next;

    // Result queue
    cst_pkg::result_t fifo_mem [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       pop;

    // Results of the current pass
    cst_pkg::result_t res_p, res_q, res_a, res_b;
    logic       p_v, q_v;
    logic [1:0] push_n;

    logic [2:0]  len_code;
    logic [7:0]  c;
    logic [W-1:0] len_inc;

    assign stage_fire = in_valid_reg && (count_reg <= 3'(DEPTH - 2));
    assign s_tready   = !in_valid_reg || stage_fire;
    assign pop        = m_tvalid && m_tready;

    // Input register transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    assign c        = in_byte_reg;
    assign len_code = (len_reg > W'(6)) ? 3'd7 : len_reg[2:0];
    assign len_inc  = sat_inc(len_reg);

    // Scanner pass: next state and up to two results
    always_comb begin
        logic again;
        logic fin;
        logic [3:0] single;
        mode_next     = mode_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        len_next      = len_reg;
        alive_next    = alive_reg;
        p_v   = 1'b0;
        q_v   = 1'b0;
        res_p = '0;
        res_q = '0;
        again = 1'b0;
        fin   = 1'b1;
        single = cst_pkg::TOK_END;

        if (in_kind_reg == cst_pkg::KIND_END) begin
            // End of buffer: flush pending token, then end token unless a slash, block comment or error was pending
            unique case (mode_reg) inside
                cst_pkg::M_SLASH: begin
                    p_v = 1'b1;
                    res_p = mk_res(cst_pkg::TOK_END, cst_pkg::ERR_UNKNOWN,
                                   tok_line_reg, tok_col_reg, CNT_ONE);
                    fin = 1'b0;
                end
                cst_pkg::M_LINE: begin
                    p_v = 1'b1;
                    res_p = mk_res(cst_pkg::TOK_CMT, cst_pkg::ERR_NONE,
                                   tok_line_reg, tok_col_reg, len_reg);
                end
                cst_pkg::M_BLOCK, cst_pkg::M_BSTAR: begin
                    p_v = 1'b1;
                    res_p = mk_res(cst_pkg::TOK_CMT, cst_pkg::ERR_UNTERM,
                                   tok_line_reg, tok_col_reg, len_reg);
                    fin = 1'b0;
                end
                cst_pkg::M_IDENT: begin
                    p_v = 1'b1;
                    res_p = mk_res(cst_pkg::ident_type(alive_reg, len_code),
                                   cst_pkg::ERR_NONE, tok_line_reg, tok_col_reg, len_reg);
                end
                cst_pkg::M_CONST: begin
                    p_v = 1'b1;
                    res_p = mk_res(cst_pkg::TOK_CONST, cst_pkg::ERR_NONE,
                                   tok_line_reg, tok_col_reg, len_reg);
                end
                cst_pkg::M_ERROR: begin
                    fin = 1'b0;
                end
                default: begin
                end
            endcase
            if (fin) begin
                q_v = 1'b1;
                res_q = mk_res(cst_pkg::TOK_END, cst_pkg::ERR_NONE,
                               cur_line_reg, cur_col_reg, '0);
            end
            mode_next     = cst_pkg::M_IDLE;
            cur_line_next = CNT_ONE;
            cur_col_next  = CNT_ONE;
            tok_line_next = CNT_ONE;
            tok_col_next  = CNT_ONE;
            len_next      = '0;
            alive_next    = 3'b111;
        end else begin
            // Source byte in the current mode
            unique case (mode_reg) inside
                cst_pkg::M_IDLE: begin
                    again = 1'b1;
                end
                cst_pkg::M_SLASH: begin
                    if (c == cst_pkg::CH_SLASH || c == cst_pkg::CH_STAR) begin
                        mode_next = (c == cst_pkg::CH_SLASH) ? cst_pkg::M_LINE
                                                             : cst_pkg::M_BLOCK;
                        len_next = len_inc;
                    end else begin
                        p_v = 1'b1;
                        res_p = mk_res(cst_pkg::TOK_END, cst_pkg::ERR_UNKNOWN,
                                       tok_line_reg, tok_col_reg, CNT_ONE);
                        mode_next = cst_pkg::M_ERROR;
                    end
                end
                cst_pkg::M_LINE: begin
                    if (c == cst_pkg::CH_NL) begin
                        p_v = 1'b1;
                        res_p = mk_res(cst_pkg::TOK_CMT, cst_pkg::ERR_NONE,
                                       tok_line_reg, tok_col_reg, len_reg);
                        mode_next = cst_pkg::M_IDLE;
                        again = 1'b1;
                    end else begin
                        len_next = len_inc;
                    end
                end
                cst_pkg::M_BLOCK, cst_pkg::M_BSTAR: begin
                    len_next = len_inc;
                    if (mode_reg == cst_pkg::M_BSTAR && c == cst_pkg::CH_SLASH) begin
                        p_v = 1'b1;
                        res_p = mk_res(cst_pkg::TOK_CMT, cst_pkg::ERR_NONE,
                                       tok_line_reg, tok_col_reg, len_inc);
                        mode_next = cst_pkg::M_IDLE;
                    end else begin
                        mode_next = (c == cst_pkg::CH_STAR) ? cst_pkg::M_BSTAR
                                                            : cst_pkg::M_BLOCK;
                    end
                end
                cst_pkg::M_IDENT: begin
                    if (cst_pkg::letter_byte(c) || cst_pkg::is_digit(c)
                        || c == cst_pkg::CH_UNDER) begin
                        alive_next = cst_pkg::kw_filter(alive_reg, len_code, c);
                        len_next = len_inc;
                    end else begin
                        p_v = 1'b1;
                        res_p = mk_res(cst_pkg::ident_type(alive_reg, len_code),
                                       cst_pkg::ERR_NONE, tok_line_reg, tok_col_reg,
                                       len_reg);
                        mode_next = cst_pkg::M_IDLE;
                        again = 1'b1;
                    end
                end
                cst_pkg::M_CONST: begin
                    if (cst_pkg::is_digit(c)) begin
                        len_next = len_inc;
                    end else if (cst_pkg::letter_byte(c)) begin
                        p_v = 1'b1;
                        res_p = mk_res(cst_pkg::TOK_CONST, cst_pkg::ERR_BADCONST,
                                       tok_line_reg, tok_col_reg, len_reg);
                        mode_next = cst_pkg::M_ERROR;
                    end else begin
                        p_v = 1'b1;
                        res_p = mk_res(cst_pkg::TOK_CONST, cst_pkg::ERR_NONE,
                                       tok_line_reg, tok_col_reg, len_reg);
                        mode_next = cst_pkg::M_IDLE;
                        again = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // Byte seen from idle: punctuation, token start or unknown
            if (again && !cst_pkg::white_byte(c)) begin
                unique case (c)
                    cst_pkg::CH_LPAR: single = cst_pkg::TOK_LPAREN;
                    cst_pkg::CH_RPAR: single = cst_pkg::TOK_RPAREN;
                    cst_pkg::CH_LBRC: single = cst_pkg::TOK_LBRACE;
                    cst_pkg::CH_RBRC: single = cst_pkg::TOK_RBRACE;
                    cst_pkg::CH_SEMI: single = cst_pkg::TOK_SEMI;
                    default:          single = cst_pkg::TOK_END;
                endcase
                if (single != cst_pkg::TOK_END) begin
                    q_v = 1'b1;
                    res_q = mk_res(single, cst_pkg::ERR_NONE,
                                   cur_line_reg, cur_col_reg, CNT_ONE);
                end else if (c == cst_pkg::CH_SLASH || cst_pkg::is_digit(c)
                             || cst_pkg::letter_byte(c)) begin
                    tok_line_next = cur_line_reg;
                    tok_col_next  = cur_col_reg;
                    len_next      = CNT_ONE;
                    if (c == cst_pkg::CH_SLASH) begin
                        mode_next = cst_pkg::M_SLASH;
                    end else if (cst_pkg::is_digit(c)) begin
                        mode_next = cst_pkg::M_CONST;
                    end else begin
                        mode_next  = cst_pkg::M_IDENT;
                        alive_next = cst_pkg::kw_filter(3'b111, 3'd0, c);
                    end
                end else begin
                    q_v = 1'b1;
                    res_q = mk_res(cst_pkg::TOK_END, cst_pkg::ERR_UNKNOWN,
                                   cur_line_reg, cur_col_reg, CNT_ONE);
                    mode_next = cst_pkg::M_ERROR;
                end
            end

            // Position update
            if (c == cst_pkg::CH_NL) begin
                cur_line_next = sat_inc(cur_line_reg);
                cur_col_next  = CNT_ONE;
            end else begin
                cur_col_next  = sat_inc(cur_col_reg);
            end
        end
    end

    // Order results into queue slots and mark the final one
    always_comb begin
        res_a = p_v ? res_p : res_q;
        res_b = res_q;
        push_n = 2'(p_v) + 2'(q_v);
        if (push_n == 2'd2) begin
            res_b.last_of_run = 1'b1;
        end else begin
            res_a.last_of_run = 1'b1;
        end
    end

    // Scanner state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= cst_pkg::M_IDLE;
            cur_line_reg <= CNT_ONE;
            cur_col_reg  <= CNT_ONE;
            tok_line_reg <= CNT_ONE;
            tok_col_reg  <= CNT_ONE;
            len_reg      <= '0;
            alive_reg    <= 3'b111;
        end else if (stage_fire) begin
            mode_reg     <= mode_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            len_reg      <= len_next;
            alive_reg    <= alive_next;
        end
    end

    // Result queue storage
    always_ff @(posedge aclk) begin
        if (stage_fire && push_n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= res_a;
        end
        if (stage_fire && push_n == 2'd2) begin
            fifo_mem[wr_ptr_reg + 2'd1] <= res_b;
        end
    end

    // Result queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (stage_fire) begin
                wr_ptr_reg <= wr_ptr_reg + push_n;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (stage_fire ? 3'(push_n) : 3'd0) - 3'(pop);
        end
    end

    // Master side
    assign m_tvalid = count_reg != 3'd0;
    assign m_tdata  = {6'd0, fifo_mem[rd_ptr_reg].token_length,
                       fifo_mem[rd_ptr_reg].start_column,
                       fifo_mem[rd_ptr_reg].start_line,
                       fifo_mem[rd_ptr_reg].error_code};
    assign m_tuser  = fifo_mem[rd_ptr_reg].token_type;
    assign m_tlast  = fifo_mem[rd_ptr_reg].last_of_run;

`include "c_subset_token_scanner_assert.svh"

    `CST_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= 3'(DEPTH), "result queue overflow")
    `CST_ASSERT_NOW(a_push_fits, stage_fire, (count_reg + 3'(push_n)) <= 3'(DEPTH), "push overruns queue")
    `CST_ASSERT_NOW(a_error_silent, stage_fire && mode_reg == cst_pkg::M_ERROR, push_n == 2'd0, "result while dropping bytes")
    `CST_ASSERT_NEXT(a_end_resets, stage_fire && in_kind_reg == cst_pkg::KIND_END, mode_reg == cst_pkg::M_IDLE && cur_line_reg == CNT_ONE && cur_col_reg == CNT_ONE, "end item did not reset scanner")

endmodule

`default_nettype wire

// ===== verif/c_subset_token_scanner_test.sv =====
// Self-checking testbench for the C subset token scanner: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module c_subset_token_scanner_test;

    localparam int RANDOM_ITEMS = 750;
    localparam int HOLDOFF_AT   = 500;      // receiver cycle where the long stall starts
    localparam int HOLDOFF_LEN  = 400;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } src_item_t;

    // DUT ports
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = cst_pkg::KIND_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // Stimulus and scoreboard
    src_item_t          source_queue[$];
    cst_pkg::result_t   expected_tokens[$];
    cst_pkg::result_t   step_results[$];
    int        total_items = 0;
    int        accepted_items = 0;
    int        token_count = 0;
    int        mismatch_count = 0;
    int        cycle_count = 0;

    // Predictor state
    cst_pkg::scan_mode_t scan_state;
    logic [15:0] cur_line, cur_col, tok_line, tok_col, tok_len;
    logic [2:0]  kw_alive;
    string       keyword_text[3] = '{"int", "void", "return"};
    logic [3:0]  keyword_token[3] = '{cst_pkg::TOK_INT, cst_pkg::TOK_VOID,
                                      cst_pkg::TOK_RETURN};

    c_subset_token_scanner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [7:0] source_byte
        .s_tuser  (s_tuser),     // [0] kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [1:0] error, [17:2] line, [33:18] column, [49:34] length
        .m_tuser  (m_tuser),     // [3:0] token_type
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == cst_pkg::CH_SPACE || c == cst_pkg::CH_TAB || c == cst_pkg::CH_NL
            || c == cst_pkg::CH_CR;
    endfunction

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Keep only keywords that still match with ch at position pos
    function automatic logic [2:0] narrow_keywords(logic [2:0] alive, int pos, logic [7:0] ch);
        logic [2:0] keep;
        keep = alive;
        for (int k = 0; k < 3; k++) begin
            if (pos >= keyword_text[k].len() || keyword_text[k][pos] != ch) keep[k] = 1'b0;
        end
        return keep;
    endfunction

    function automatic logic [3:0] word_token();
        for (int k = 0; k < 3; k++) begin
            if (kw_alive[k] && tok_len == keyword_text[k].len()) return keyword_token[k];
        end
        return cst_pkg::TOK_IDENT;
    endfunction

    task automatic clear_scanner();
        scan_state = cst_pkg::M_IDLE;
        cur_line   = 16'd1;
        cur_col    = 16'd1;
        tok_line   = 16'd1;
        tok_col    = 16'd1;
        tok_len    = 16'd0;
        kw_alive   = 3'b111;
    endtask

    task automatic emit(input logic [3:0] tt, input logic [1:0] err, input logic [15:0] line,
                        input logic [15:0] col, input logic [15:0] len);
        cst_pkg::result_t r;
        r.token_type   = tt;
        r.error_code   = err;
        r.start_line   = line;
        r.start_column = col;
        r.token_length = len;
        r.last_of_run  = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic open_token(input cst_pkg::scan_mode_t m);
        scan_state = m;
        tok_line   = cur_line;
        tok_col    = cur_col;
        tok_len    = 16'd1;
    endtask

    // Advance the scanner by one accepted transfer and queue its tokens
    task automatic scan_item(input logic kind, input logic [7:0] ch);
        logic       rescan;
        logic       finish;
        logic [3:0] punct;
        rescan = 1'b0;
        step_results.delete();
        if (kind == cst_pkg::KIND_END) begin
            // flush the pending token, then the end token unless a slash, block comment or error is pending
            finish = 1'b1;
            case (scan_state) inside
                cst_pkg::M_SLASH: begin
                    emit(cst_pkg::TOK_END, cst_pkg::ERR_UNKNOWN, tok_line, tok_col, 16'd1);
                    finish = 1'b0;
                end
                cst_pkg::M_LINE: begin
                    emit(cst_pkg::TOK_CMT, cst_pkg::ERR_NONE, tok_line, tok_col, tok_len);
                end
                cst_pkg::M_BLOCK, cst_pkg::M_BSTAR: begin
                    emit(cst_pkg::TOK_CMT, cst_pkg::ERR_UNTERM, tok_line, tok_col, tok_len);
                    finish = 1'b0;
                end
                cst_pkg::M_IDENT: begin
                    emit(word_token(), cst_pkg::ERR_NONE, tok_line, tok_col, tok_len);
                end
                cst_pkg::M_CONST: begin
                    emit(cst_pkg::TOK_CONST, cst_pkg::ERR_NONE, tok_line, tok_col, tok_len);
                end
                cst_pkg::M_ERROR: finish = 1'b0;
                default: ;
            endcase
            if (finish) emit(cst_pkg::TOK_END, cst_pkg::ERR_NONE, cur_line, cur_col, 16'd0);
            clear_scanner();
        end else begin
            case (scan_state) inside
                cst_pkg::M_IDLE: rescan = 1'b1;
                cst_pkg::M_SLASH: begin
                    if (ch == cst_pkg::CH_SLASH || ch == cst_pkg::CH_STAR) begin
                        scan_state = (ch == cst_pkg::CH_SLASH) ? cst_pkg::M_LINE
                                                               : cst_pkg::M_BLOCK;
                        tok_len = bump(tok_len);
                    end else begin
                        emit(cst_pkg::TOK_END, cst_pkg::ERR_UNKNOWN, tok_line, tok_col,
                             16'd1);
                        scan_state = cst_pkg::M_ERROR;
                    end
                end
                cst_pkg::M_LINE: begin
                    if (ch == cst_pkg::CH_NL) begin
                        emit(cst_pkg::TOK_CMT, cst_pkg::ERR_NONE, tok_line, tok_col, tok_len);
                        scan_state = cst_pkg::M_IDLE;
                        rescan = 1'b1;
                    end else begin
                        tok_len = bump(tok_len);
                    end
                end
                cst_pkg::M_BLOCK, cst_pkg::M_BSTAR: begin
                    // the closing slash counts; the opening star cannot close
                    tok_len = bump(tok_len);
                    if (scan_state == cst_pkg::M_BSTAR && ch == cst_pkg::CH_SLASH) begin
                        emit(cst_pkg::TOK_CMT, cst_pkg::ERR_NONE, tok_line, tok_col, tok_len);
                        scan_state = cst_pkg::M_IDLE;
                    end else begin
                        scan_state = (ch == cst_pkg::CH_STAR) ? cst_pkg::M_BSTAR
                                                              : cst_pkg::M_BLOCK;
                    end
                end
                cst_pkg::M_IDENT: begin
                    if (is_letter(ch) || is_numeral(ch) || ch == cst_pkg::CH_UNDER) begin
                        kw_alive = narrow_keywords(kw_alive, int'(tok_len), ch);
                        tok_len = bump(tok_len);
                    end else begin
                        emit(word_token(), cst_pkg::ERR_NONE, tok_line, tok_col, tok_len);
                        scan_state = cst_pkg::M_IDLE;
                        rescan = 1'b1;
                    end
                end
                cst_pkg::M_CONST: begin
                    if (is_numeral(ch)) begin
                        tok_len = bump(tok_len);
                    end else if (is_letter(ch)) begin
                        emit(cst_pkg::TOK_CONST, cst_pkg::ERR_BADCONST, tok_line, tok_col,
                             tok_len);
                        scan_state = cst_pkg::M_ERROR;
                    end else begin
                        emit(cst_pkg::TOK_CONST, cst_pkg::ERR_NONE, tok_line, tok_col,
                             tok_len);
                        scan_state = cst_pkg::M_IDLE;
                        rescan = 1'b1;
                    end
                end
                default: ;
            endcase

            // byte seen from idle: may start a token or give a second result
            if (rescan && !is_blank(ch)) begin
                case (ch)
                    cst_pkg::CH_LPAR: punct = cst_pkg::TOK_LPAREN;
                    cst_pkg::CH_RPAR: punct = cst_pkg::TOK_RPAREN;
                    cst_pkg::CH_LBRC: punct = cst_pkg::TOK_LBRACE;
                    cst_pkg::CH_RBRC: punct = cst_pkg::TOK_RBRACE;
                    cst_pkg::CH_SEMI: punct = cst_pkg::TOK_SEMI;
                    default:          punct = cst_pkg::TOK_END;
                endcase
                if (punct != cst_pkg::TOK_END) begin
                    emit(punct, cst_pkg::ERR_NONE, cur_line, cur_col, 16'd1);
                end else if (ch == cst_pkg::CH_SLASH) begin
                    open_token(cst_pkg::M_SLASH);
                end else if (is_numeral(ch)) begin
                    open_token(cst_pkg::M_CONST);
                end else if (is_letter(ch)) begin
                    open_token(cst_pkg::M_IDENT);
                    kw_alive = narrow_keywords(3'b111, 0, ch);
                end else begin
                    emit(cst_pkg::TOK_END, cst_pkg::ERR_UNKNOWN, cur_line, cur_col, 16'd1);
                    scan_state = cst_pkg::M_ERROR;
                end
            end

            if (ch == cst_pkg::CH_NL) begin
                cur_line = bump(cur_line);
                cur_col  = 16'd1;
            end else begin
                cur_col = bump(cur_col);
            end
        end

        if (step_results.size() != 0) step_results[$].last_of_run = 1'b1;
        foreach (step_results[i]) expected_tokens.push_back(step_results[i]);
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic add_byte(input logic [7:0] ch);
        src_item_t it;
        it.kind = cst_pkg::KIND_BYTE;
        it.ch   = ch;
        source_queue.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // end of buffer; the data byte is don't-care, so randomize it
    task automatic add_end();
        src_item_t it;
        it.kind = cst_pkg::KIND_END;
        it.ch   = 8'($urandom_range(0, 255));
        source_queue.push_back(it);
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] ident_char();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return cst_pkg::CH_UNDER;
        if (r < 4) return rand_digit();
        return rand_letter();
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return cst_pkg::CH_SPACE;
            1: return cst_pkg::CH_TAB;
            2: return cst_pkg::CH_CR;
            default: return cst_pkg::CH_NL;
        endcase
    endfunction

    // One buffer of mostly well-formed tokens, ended by an end-of-buffer item
    task automatic add_random_buffer();
        int         tokens;
        int         t;
        logic       cut;
        string      word;
        logic [7:0] b;
        tokens = $urandom_range(1, 10);
        cut = 1'b0;
        for (t = 0; t < tokens && !cut; t++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: add_text(keyword_text[$urandom_range(0, 2)]);
                3: begin
                    // keyword one char short or one char long
                    word = keyword_text[$urandom_range(0, 2)];
                    if ($urandom_range(0, 1)) begin
                        add_text(word.substr(0, word.len() - 2));
                    end else begin
                        add_text(word);
                        add_byte(ident_char());
                    end
                end
                4, 5, 6: begin
                    add_byte(rand_letter());
                    repeat ($urandom_range(0, 7)) add_byte(ident_char());
                end
                7, 8: repeat ($urandom_range(1, 6)) add_byte(rand_digit());
                9, 10, 11: begin
                    case ($urandom_range(0, 4))
                        0: add_byte(cst_pkg::CH_LPAR);
                        1: add_byte(cst_pkg::CH_RPAR);
                        2: add_byte(cst_pkg::CH_LBRC);
                        3: add_byte(cst_pkg::CH_RBRC);
                        default: add_byte(cst_pkg::CH_SEMI);
                    endcase
                end
                12: begin
                    add_text("//");
                    repeat ($urandom_range(0, 10)) begin
                        do b = 8'($urandom_range(0, 255)); while (b == cst_pkg::CH_NL);
                        add_byte(b);
                    end
                    if ($urandom_range(0, 4) != 0) add_byte(cst_pkg::CH_NL);
                end
                13: begin
                    add_text("/*");
                    repeat ($urandom_range(0, 10)) begin
                        case ($urandom_range(0, 3))
                            0: add_byte(cst_pkg::CH_STAR);
                            1: add_byte(cst_pkg::CH_SLASH);
                            2: add_byte(cst_pkg::CH_NL);
                            default: add_byte(8'($urandom_range(0, 255)));
                        endcase
                    end
                    add_text("*/");
                end
                14, 15, 16: repeat ($urandom_range(1, 3)) add_byte(blank_char());
                17: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            add_byte(rand_digit());
                            add_byte(rand_letter());
                        end
                        1: begin
                            add_byte(cst_pkg::CH_SLASH);
                            do b = 8'($urandom_range(0, 255));
                            while (b == cst_pkg::CH_SLASH || b == cst_pkg::CH_STAR);
                            add_byte(b);
                        end
                        2: add_byte(cst_pkg::CH_UNDER);
                        default: add_byte(8'($urandom_range(128, 255)));
                    endcase
                end
                18: add_byte(8'($urandom_range(0, 255)));
                default: begin
                    // comment still open when the buffer ends
                    add_text("/*");
                    repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
                    cut = 1'b1;
                end
            endcase
            if (!cut && $urandom_range(0, 1)) add_byte(blank_char());
        end
        add_end();
    endtask

    // ---------------------------------------------------------------- driver

    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge aclk) begin
        src_item_t item;
        logic      load;
        load = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_item(s_tuser, s_tdata);
                accepted_items++;
            end
            // bus free: either idle a gap cycle or offer the next item
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (source_queue.size() != 0) begin
                    item = source_queue.pop_front();
                    load = 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                if (load) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.ch;
                    s_tuser  <= item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    int rx_cycles    = 0;
    int holdoff_left = 0;
    int phase_left   = 0;
    int ready_pct    = 100;

    always @(posedge aclk) begin
        logic ready;
        rx_cycles++;
        if (rx_cycles == HOLDOFF_AT) holdoff_left = HOLDOFF_LEN;
        if (holdoff_left != 0) begin
            // long stall: the result queue fills and s_tready must drop
            holdoff_left--;
            ready = 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 150);
                case ($urandom_range(0, 4))
                    0, 1: ready_pct = 100;
                    2: ready_pct = 70;
                    3: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end
            phase_left--;
            ready = ($urandom_range(0, 99) < ready_pct);
        end
        m_tready <= ready;
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40) $display("MISMATCH token %0d: %s", token_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge aclk) begin
        cst_pkg::result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, type %0d", m_tuser));
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_type", 16'(m_tuser), 16'(want.token_type));
                check_field("error_code", 16'(m_tdata[1:0]), 16'(want.error_code));
                check_field("start_line", m_tdata[17:2], want.start_line);
                check_field("start_column", m_tdata[33:18], want.start_column);
                check_field("token_length", m_tdata[49:34], want.token_length);
                check_field("last_of_run", 16'(m_tlast), 16'(want.last_of_run));
            end
            token_count++;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int directed_total;
        clear_scanner();

        // slash star slash stays open: unterminated comment at end
        add_text("/*/");
        add_end();
        // digits then a letter; end item after an error gives nothing
        add_text("12a");
        add_end();
        // lone slash: the following byte is dropped
        add_text("/a");
        add_end();
        // lone slash ended by the end item
        add_byte(cst_pkg::CH_SLASH);
        add_end();
        // leading underscore and a high byte are unknown characters
        add_byte(cst_pkg::CH_UNDER);
        add_end();
        add_byte(8'hFF);
        add_end();
        // keyword ended by a punctuator: two results from one byte
        add_text("int;");
        add_end();
        directed_total = source_queue.size();

        while (source_queue.size() < directed_total + RANDOM_ITEMS) add_random_buffer();
        total_items = source_queue.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_items != total_items) @(negedge aclk);
        while (expected_tokens.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        report_mismatch($sformatf("timeout, %0d of %0d items accepted",
                                  accepted_items, total_items));
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== c_subset_token_scanner.f =====
+incdir+rtl
rtl/cst_pkg.sv
rtl/c_subset_token_scanner.sv
verif/c_subset_token_scanner_test.sv
